// ----- rtl/wmts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmts_pkg
// Shared widths, register indexes, reset values and the interface types
// between the trace scaler top level and its ceiling divider.
// ----------------------------------------------------------------------------
package wmts_pkg;

  // Default size of the sample window and horizontal pixel pitch.
  localparam int WINDOW_DEF = 25;
  localparam int X_STEP_DEF = 5;

  // Field widths.
  localparam int SAMPLE_W = 15;
  localparam int MARGIN_W = 7;
  localparam int ROW_W    = 6;
  localparam int IDX_W    = 5;
  localparam int XPOS_W   = 8;

  // Internal arithmetic widths.
  localparam int WIDE_W = SAMPLE_W + 2;      // widened limits, signed
  localparam int DEN_W  = 16;                // hi - lo, never negative
  localparam int NUM_W  = ROW_W + DEN_W;     // span_rows * (t - lo)
  localparam int QUO_W  = ROW_W;             // quotient never exceeds span_rows

  // Stream widths.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_ABOVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CEILING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_ROW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_ROWS    = 3'd5;

  // Register reset values.
  localparam logic signed [SAMPLE_W-1:0] RST_REJECT_ABOVE = 15'sd11500;
  localparam logic signed [SAMPLE_W-1:0] RST_MAX_FLOOR    = 15'sd0;
  localparam logic signed [SAMPLE_W-1:0] RST_MIN_CEILING  = 15'sd11500;
  localparam logic [MARGIN_W-1:0]        RST_MARGIN       = 7'd5;
  localparam logic [ROW_W-1:0]           RST_BASELINE_ROW = 6'd63;
  localparam logic [ROW_W-1:0]           RST_SPAN_ROWS    = 6'd33;

  // Saturation limits of the 15 bit labels, in the widened format.
  localparam logic signed [WIDE_W-1:0] LABEL_MAX = 17'sd16383;
  localparam logic signed [WIDE_W-1:0] LABEL_MIN = -17'sd16384;

  // Request to the ceiling divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // Response of the ceiling divider.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- rtl/wmts_window_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmts_window_mem
// Sample window storage: one write port, one read port with registered data.
// Entries never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module wmts_window_mem #(
  parameter int DEPTH = wmts_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  logic signed [wmts_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                                 rd_en,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  output logic signed [wmts_pkg::SAMPLE_W-1:0] rd_data
);

  logic signed [wmts_pkg::SAMPLE_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]                     vld_r;
  logic signed [wmts_pkg::SAMPLE_W-1:0] rdata_r;
  logic                                 rvld_r;

  // Storage array and registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  // Valid bits stand in for the all-zero reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

// ----- rtl/wmts_ceil_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmts_ceil_div
// Restoring divider giving ceil(num / den), one quotient bit per cycle.
// The quotient is known to fit in QUO_W bits; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module wmts_ceil_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wmts_pkg::div_req_t req,
  output wmts_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(wmts_pkg::QUO_W);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [STEP_W-1:0]              step_r, step_nxt;
  logic [wmts_pkg::NUM_W-1:0]     rem_r, rem_nxt;
  logic [wmts_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [wmts_pkg::QUO_W-1:0]     q_r, q_nxt;
  logic [wmts_pkg::NUM_W-1:0]     shifted;
  logic [wmts_pkg::QUO_W:0]       q_ceil;

  // One compare and subtract of the shifted divisor per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    shifted  = wmts_pkg::NUM_W'(den_r) << step_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(wmts_pkg::QUO_W - 1);
      rem_nxt  = req.num;
      den_nxt  = req.den;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (rem_r >= shifted) begin
        rem_nxt        = rem_r - shifted;
        q_nxt[step_r]  = 1'b1;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
  end

  // Round up when a remainder is left.
  assign q_ceil   = {1'b0, q_r} + {{wmts_pkg::QUO_W{1'b0}}, (rem_r != '0)};
  assign rsp.done = done_r;
  assign rsp.quo  = (den_r == '0) ? '0 : q_ceil[wmts_pkg::QUO_W-1:0];

endmodule

// ----- rtl/window_minmax_trace_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_minmax_trace_scaler
// Keeps a sliding window of temperature samples, finds its widened min and
// max, and emits one scaled plot point per window entry, oldest first.
//
//  Channel  Direction  Payload
//  in_      slave      tdata[14:0] sample
//  out_     master     tdata point_index, x_pos, y_row, upper_label,
//                      lower_label; tlast = last
//  cfg_     slave      cfg_index selects register, cfg_data is the value
//
// A rejected sample is dropped and the block stays idle. An accepted sample is
// written, then the min/max walk reads the whole window memory; each point then
// takes a read, a multiply and a one-bit-per-cycle ceiling division.
// in_tready is high only while no sample is in work. Output stalls hold the
// current point in its register. Reset is synchronous and needs no clearing.
// ----------------------------------------------------------------------------
module window_minmax_trace_scaler #(
  parameter int WINDOW = wmts_pkg::WINDOW_DEF,
  parameter int X_STEP = wmts_pkg::X_STEP_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input beats: [14:0] sample, [15] zero.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [wmts_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Output beats: [4:0] point_index, [12:5] x_pos, [18:13] y_row,
  // [33:19] upper_label, [48:34] lower_label, [55:49] zero.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wmts_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wmts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wmts_pkg::SAMPLE_W-1:0]        cfg_data
);

  localparam int AW  = $clog2(WINDOW);
  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SW  = wmts_pkg::SAMPLE_W;
  localparam int WW  = wmts_pkg::WIDE_W;
  localparam int XPW = wmts_pkg::IDX_W + 8;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DIVGO = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // Configuration registers.
  logic signed [SW-1:0]                 reject_above_r, max_floor_r, min_ceiling_r;
  logic [wmts_pkg::MARGIN_W-1:0]        margin_r;
  logic [wmts_pkg::ROW_W-1:0]           baseline_r, span_r;

  // Control state.
  state_t                               state_r, state_nxt;
  logic [AW-1:0]                        wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]                        rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]                        cnt_r, cnt_nxt;
  logic [wmts_pkg::IDX_W-1:0]           idx_r, idx_nxt;

  // Datapath registers.
  logic signed [SW-1:0]                 mx_r, mx_nxt, mn_r, mn_nxt;
  logic signed [WW-1:0]                 lo_r, lo_nxt;
  logic [wmts_pkg::DEN_W-1:0]           den_r, den_nxt;
  logic [wmts_pkg::NUM_W-1:0]           num_r, num_nxt;
  logic [SW-1:0]                        upper_r, upper_nxt, lower_r, lower_nxt;
  logic [wmts_pkg::ROW_W-1:0]           y_r, y_nxt;
  logic [wmts_pkg::XPOS_W-1:0]          x_r, x_nxt;

  // Memory and divider connections.
  logic                                 mem_we, mem_re;
  logic signed [SW-1:0]                 mem_rdata;
  logic signed [SW-1:0]                 sample;
  wmts_pkg::div_req_t                   div_req;
  wmts_pkg::div_rsp_t                   div_rsp;

  // Helper values.
  logic                                 in_acc, reject;
  logic signed [WW-1:0]                 hi_w, lo_w;
  logic signed [WW:0]                   den_w, diff_w;
  logic signed [7:0]                    y_w;
  logic [XPW-1:0]                       x_w;

  assign sample    = $signed(in_tdata[SW-1:0]);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign reject    = (sample > reject_above_r);
  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reject_above_r <= wmts_pkg::RST_REJECT_ABOVE;
      max_floor_r    <= wmts_pkg::RST_MAX_FLOOR;
      min_ceiling_r  <= wmts_pkg::RST_MIN_CEILING;
      margin_r       <= wmts_pkg::RST_MARGIN;
      baseline_r     <= wmts_pkg::RST_BASELINE_ROW;
      span_r         <= wmts_pkg::RST_SPAN_ROWS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wmts_pkg::REG_REJECT_ABOVE: reject_above_r <= $signed(cfg_data);
        wmts_pkg::REG_MAX_FLOOR:    max_floor_r    <= $signed(cfg_data);
        wmts_pkg::REG_MIN_CEILING:  min_ceiling_r  <= $signed(cfg_data);
        wmts_pkg::REG_MARGIN:       margin_r       <= cfg_data[wmts_pkg::MARGIN_W-1:0];
        wmts_pkg::REG_BASELINE_ROW: baseline_r     <= cfg_data[wmts_pkg::ROW_W-1:0];
        wmts_pkg::REG_SPAN_ROWS:    span_r         <= cfg_data[wmts_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Window memory; the oldest entry sits at the write pointer.
  wmts_window_mem #(
    .DEPTH (WINDOW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (wr_ptr_r),
    .wr_data (sample),
    .rd_en   (mem_re),
    .rd_addr (rd_ptr_r),
    .rd_data (mem_rdata)
  );

  // Ceiling divider for the row scaling.
  wmts_ceil_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign div_req.start = (state_r == S_DIVGO);
  assign div_req.num   = num_r;
  assign div_req.den   = den_r;

  // Widened limits and their difference.
  assign hi_w   = WW'(mx_r) + WW'({1'b0, margin_r});
  assign lo_w   = WW'(mn_r) - WW'({1'b0, margin_r});
  assign den_w  = (WW+1)'(mx_r) - (WW+1)'(mn_r) + (WW+1)'({1'b0, margin_r, 1'b0});
  assign diff_w = (WW+1)'(mem_rdata) - (WW+1)'(lo_r);
  assign y_w    = $signed({2'b00, baseline_r}) - $signed({2'b00, div_rsp.quo});
  assign x_w    = (XPW'(idx_r) + XPW'(1)) * XPW'(X_STEP);

  // Sequencer: accept, min/max walk, then one point at a time.
  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    mx_nxt     = mx_r;
    mn_nxt     = mn_r;
    lo_nxt     = lo_r;
    den_nxt    = den_r;
    num_nxt    = num_r;
    upper_nxt  = upper_r;
    lower_nxt  = lower_r;
    y_nxt      = y_r;
    x_nxt      = x_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !reject) begin
          mem_we     = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == AW'(WINDOW - 1)) ? '0 : wr_ptr_r + 1'b1;
          rd_ptr_nxt = wr_ptr_nxt;
          cnt_nxt    = '0;
          mx_nxt     = max_floor_r;
          mn_nxt     = min_ceiling_r;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != CW'(WINDOW)) begin
          mem_re     = 1'b1;
          rd_ptr_nxt = (rd_ptr_r == AW'(WINDOW - 1)) ? '0 : rd_ptr_r + 1'b1;
        end
        if (cnt_r != '0) begin
          if (mem_rdata > mx_r) mx_nxt = mem_rdata;
          if (mem_rdata < mn_r) mn_nxt = mem_rdata;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(WINDOW)) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        lo_nxt  = lo_w;
        den_nxt = den_w[wmts_pkg::DEN_W-1:0];
        if (hi_w > wmts_pkg::LABEL_MAX)      upper_nxt = wmts_pkg::LABEL_MAX[SW-1:0];
        else if (hi_w < wmts_pkg::LABEL_MIN) upper_nxt = wmts_pkg::LABEL_MIN[SW-1:0];
        else                                 upper_nxt = hi_w[SW-1:0];
        if (lo_w > wmts_pkg::LABEL_MAX)      lower_nxt = wmts_pkg::LABEL_MAX[SW-1:0];
        else if (lo_w < wmts_pkg::LABEL_MIN) lower_nxt = wmts_pkg::LABEL_MIN[SW-1:0];
        else                                 lower_nxt = lo_w[SW-1:0];
        idx_nxt    = '0;
        mem_re     = 1'b1;
        rd_ptr_nxt = (rd_ptr_r == AW'(WINDOW - 1)) ? '0 : rd_ptr_r + 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        // The entry is never below lo, so the difference is unsigned.
        num_nxt   = wmts_pkg::NUM_W'(span_r) *
                    wmts_pkg::NUM_W'(diff_w[wmts_pkg::DEN_W-1:0]);
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          y_nxt     = y_w[7] ? '0 : y_w[wmts_pkg::ROW_W-1:0];
          x_nxt     = x_w[wmts_pkg::XPOS_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (idx_r == wmts_pkg::IDX_W'(WINDOW - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt    = idx_r + 1'b1;
            mem_re     = 1'b1;
            rd_ptr_nxt = (rd_ptr_r == AW'(WINDOW - 1)) ? '0 : rd_ptr_r + 1'b1;
            state_nxt  = S_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mx_r    <= mx_nxt;
    mn_r    <= mn_nxt;
    lo_r    <= lo_nxt;
    den_r   <= den_nxt;
    num_r   <= num_nxt;
    upper_r <= upper_nxt;
    lower_r <= lower_nxt;
    y_r     <= y_nxt;
    x_r     <= x_nxt;
  end

  // Output beat.
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = (idx_r == wmts_pkg::IDX_W'(WINDOW - 1));
  assign out_tdata  = {7'd0, lower_r, upper_r, y_r, x_r, idx_r};

  // The input and output sides never hold a beat at once.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a point is pending");

  // An accepted, kept sample always starts the window walk.
  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !reject) |=> (state_r == S_SCAN))
    else $error("kept sample did not start the scan");

  // A rejected sample leaves the block idle and the window untouched.
  a_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && reject) |=> (state_r == S_IDLE) && $stable(wr_ptr_r))
    else $error("rejected sample changed state");

  // The divider only reports while a point waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider result outside the divide state");

  // A row never lies below the baseline.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (y_r <= baseline_r))
    else $error("row beyond baseline");

endmodule
